// ===== rtl/core/prp_pkg.sv =====
// prp_pkg: widths, constants, register codes and beat types for the point rotate and
// project block. Used by every module in rtl/core; depends on nothing.
package prp_pkg;

	localparam int COORD_W = 16;
	localparam int TRIG_W = 16;
	localparam int TRIG_FRAC_BITS = 14;
	localparam int CFG_W = 16;
	localparam int OUT_W = 16;

	// growth of a rotated value per axis: one product shifted down, plus one add
	localparam int GROW = (TRIG_W + 1 > TRIG_FRAC_BITS) ? (TRIG_W + 1 - TRIG_FRAC_BITS) : 0;
	localparam int ROT_W = COORD_W + 2 * GROW;
	localparam int PROD_W = ROT_W + TRIG_W;
	localparam int TERM_W = PROD_W - TRIG_FRAC_BITS;
	localparam int SUM_W = (TERM_W + 1 > ROT_W) ? (TERM_W + 1) : ROT_W;

	// oblique factor 0.3 as 19661 / 2^16
	localparam int OBL_NUM_W = 17;
	localparam logic signed [OBL_NUM_W-1:0] OBL_NUM = 17'sd19661;
	localparam int OBL_SHIFT = 16;
	localparam int OBL_PROD_W = ROT_W + OBL_NUM_W;
	localparam int OBL_W = OBL_PROD_W - OBL_SHIFT;

	localparam int HALF_W = CFG_W - 1;
	localparam int FIN_W = SUM_W + 2;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

	localparam logic signed [TRIG_W-1:0] RST_COS = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] RST_SIN = 16'sd0;
	localparam logic [CFG_W-1:0] RST_SIZE = 16'd4096;

	typedef enum logic [2:0] {
		REG_COS_X = 3'd0,
		REG_SIN_X = 3'd1,
		REG_COS_Y = 3'd2,
		REG_SIN_Y = 3'd3,
		REG_COS_Z = 3'd4,
		REG_SIN_Z = 3'd5,
		REG_SCREEN_WIDTH = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] cos_x;
		logic signed [TRIG_W-1:0] sin_x;
		logic signed [TRIG_W-1:0] cos_y;
		logic signed [TRIG_W-1:0] sin_y;
		logic signed [TRIG_W-1:0] cos_z;
		logic signed [TRIG_W-1:0] sin_z;
		logic [CFG_W-1:0] screen_width;
		logic [CFG_W-1:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic [OUT_W-1:0] screen_x;
		logic [OUT_W-1:0] screen_y;
	} screen_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] p_ac;
		logic signed [TERM_W-1:0] p_bs;
		logic signed [TERM_W-1:0] p_as;
		logic signed [TERM_W-1:0] p_bc;
		logic signed [ROT_W-1:0] pass;
	} rot_t;

endpackage

// ===== rtl/core/prp_cfg.sv =====
// prp_cfg: configuration register file with write decode and reset values.
// Depends on prp_pkg.
module prp_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [prp_pkg::CFG_W-1:0] cfg_data,
	output prp_pkg::cfg_t cfg
);

	prp_pkg::cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cos_x <= prp_pkg::RST_COS;
			regs_q.sin_x <= prp_pkg::RST_SIN;
			regs_q.cos_y <= prp_pkg::RST_COS;
			regs_q.sin_y <= prp_pkg::RST_SIN;
			regs_q.cos_z <= prp_pkg::RST_COS;
			regs_q.sin_z <= prp_pkg::RST_SIN;
			regs_q.screen_width <= prp_pkg::RST_SIZE;
			regs_q.screen_height <= prp_pkg::RST_SIZE;
		end else if (cfg_we) begin
			unique case (prp_pkg::reg_idx_t'(cfg_idx))
				prp_pkg::REG_COS_X: regs_q.cos_x <= $signed(cfg_data);
				prp_pkg::REG_SIN_X: regs_q.sin_x <= $signed(cfg_data);
				prp_pkg::REG_COS_Y: regs_q.cos_y <= $signed(cfg_data);
				prp_pkg::REG_SIN_Y: regs_q.sin_y <= $signed(cfg_data);
				prp_pkg::REG_COS_Z: regs_q.cos_z <= $signed(cfg_data);
				prp_pkg::REG_SIN_Z: regs_q.sin_z <= $signed(cfg_data);
				prp_pkg::REG_SCREEN_WIDTH: regs_q.screen_width <= cfg_data;
				prp_pkg::REG_SCREEN_HEIGHT: regs_q.screen_height <= cfg_data;
				default: regs_q <= regs_q;
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

// ===== rtl/core/prp_rot.sv =====
// prp_rot: one axis rotation stage; four coordinate by cos/sin products, each floored
// by the fraction bits and registered, then combined into difference and sum. Depends on prp_pkg.
module prp_rot (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic signed [prp_pkg::ROT_W-1:0] a,
	input logic signed [prp_pkg::ROT_W-1:0] b,
	input logic signed [prp_pkg::ROT_W-1:0] pass,
	input logic signed [prp_pkg::TRIG_W-1:0] coef_c,
	input logic signed [prp_pkg::TRIG_W-1:0] coef_s,
	output logic done,
	output logic signed [prp_pkg::ROT_W-1:0] held,
	output logic signed [prp_pkg::SUM_W-1:0] dif,
	output logic signed [prp_pkg::SUM_W-1:0] sum
);

	logic signed [prp_pkg::PROD_W-1:0] m_ac;
	logic signed [prp_pkg::PROD_W-1:0] m_bs;
	logic signed [prp_pkg::PROD_W-1:0] m_as;
	logic signed [prp_pkg::PROD_W-1:0] m_bc;
	prp_pkg::rot_t nxt;
	prp_pkg::rot_t rot_s1;
	logic vld_s1;

	assign m_ac = a * coef_c;
	assign m_bs = b * coef_s;
	assign m_as = a * coef_s;
	assign m_bc = b * coef_c;

	// floor shift is a plain drop of the fraction bits
	always_comb begin
		nxt.p_ac = $signed(m_ac[prp_pkg::PROD_W-1:prp_pkg::TRIG_FRAC_BITS]);
		nxt.p_bs = $signed(m_bs[prp_pkg::PROD_W-1:prp_pkg::TRIG_FRAC_BITS]);
		nxt.p_as = $signed(m_as[prp_pkg::PROD_W-1:prp_pkg::TRIG_FRAC_BITS]);
		nxt.p_bc = $signed(m_bc[prp_pkg::PROD_W-1:prp_pkg::TRIG_FRAC_BITS]);
		nxt.pass = pass;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rot_s1 <= nxt;
	end

	assign done = vld_s1;
	assign held = rot_s1.pass;
	assign dif = prp_pkg::SUM_W'($signed(rot_s1.p_ac)) - prp_pkg::SUM_W'($signed(rot_s1.p_bs));
	assign sum = prp_pkg::SUM_W'($signed(rot_s1.p_as)) + prp_pkg::SUM_W'($signed(rot_s1.p_bc));

endmodule

// ===== rtl/core/prp_proj.sv =====
// prp_proj: oblique projection; depth term product, then screen offset add and
// saturation to the output range over two register stages. Depends on prp_pkg.
module prp_proj (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic signed [prp_pkg::SUM_W-1:0] rx,
	input logic signed [prp_pkg::SUM_W-1:0] ry,
	input logic signed [prp_pkg::ROT_W-1:0] rz,
	input logic [prp_pkg::HALF_W-1:0] half_w,
	input logic [prp_pkg::HALF_W-1:0] half_h,
	output logic done,
	output prp_pkg::screen_t result
);

	logic signed [prp_pkg::OBL_PROD_W-1:0] m_obl;
	logic signed [prp_pkg::OBL_W-1:0] obl_s1;
	logic signed [prp_pkg::SUM_W-1:0] x_s1;
	logic signed [prp_pkg::SUM_W-1:0] y_s1;
	logic vld_s1;
	logic vld_s2;
	logic signed [prp_pkg::FIN_W-1:0] fin_x;
	logic signed [prp_pkg::FIN_W-1:0] fin_y;
	prp_pkg::screen_t res_s2;

	function automatic logic [prp_pkg::OUT_W-1:0] sat(input logic signed [prp_pkg::FIN_W-1:0] v);
		logic [prp_pkg::OUT_W-1:0] r;
		if (v[prp_pkg::FIN_W-1]) begin
			r = '0;
		end else if (|v[prp_pkg::FIN_W-2:prp_pkg::OUT_W]) begin
			r = prp_pkg::OUT_MAX;
		end else begin
			r = v[prp_pkg::OUT_W-1:0];
		end
		return r;
	endfunction

	assign m_obl = rz * prp_pkg::OBL_NUM;

	always_comb begin
		fin_x = prp_pkg::FIN_W'(x_s1) + prp_pkg::FIN_W'(obl_s1)
			+ $signed({{(prp_pkg::FIN_W-prp_pkg::HALF_W){1'b0}}, half_w});
		fin_y = prp_pkg::FIN_W'(y_s1) + prp_pkg::FIN_W'(obl_s1)
			+ $signed({{(prp_pkg::FIN_W-prp_pkg::HALF_W){1'b0}}, half_h});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		obl_s1 <= $signed(m_obl[prp_pkg::OBL_PROD_W-1:prp_pkg::OBL_SHIFT]);
		x_s1 <= rx;
		y_s1 <= ry;
		res_s2.screen_x <= sat(fin_x);
		res_s2.screen_y <= sat(fin_y);
	end

	assign done = vld_s2;
	assign result = res_s2;

endmodule

// ===== rtl/core/point_rotate_project_unit.sv =====
// point_rotate_project_unit: top level; X, Y, Z rotation stages and the oblique projection.
// Depends on prp_pkg, prp_cfg, prp_rot, prp_proj.
//
// channel  | signals                    | beat taken when
// ---------+----------------------------+-----------------------------
// input    | start, busy, point         | start high and busy low
// result   | done, result               | done high, one cycle only
// config   | cfg_we, cfg_idx, cfg_data  | cfg_we high
//
// one point enters per cycle; busy stays low, the pipeline never stops
// the pipeline has three rotation stages and two projection stages
// each rotation stage holds four multiplies; products are floored before the adds
// reset clears the valid bits and loads the register defaults
// no stall path: done is a one-cycle strobe the receiver must take
module point_rotate_project_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input prp_pkg::point_t point,
	output logic done,
	output prp_pkg::screen_t result,
	input logic cfg_we,
	input logic [2:0] cfg_idx,
	input logic [prp_pkg::CFG_W-1:0] cfg_data
);

	prp_pkg::cfg_t cfg;
	logic go;
	logic v1, v2, v3;
	logic signed [prp_pkg::ROT_W-1:0] in_x, in_y, in_z;
	logic signed [prp_pkg::ROT_W-1:0] h1, h2, h3;
	logic signed [prp_pkg::SUM_W-1:0] d1, d2, d3;
	logic signed [prp_pkg::SUM_W-1:0] s1, s2, s3;

	assign busy = 1'b0;
	assign go = start & ~busy;

	assign in_x = prp_pkg::ROT_W'($signed(point.point_x));
	assign in_y = prp_pkg::ROT_W'($signed(point.point_y));
	assign in_z = prp_pkg::ROT_W'($signed(point.point_z));

	prp_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// about x: y1 = dif, z1 = sum
	prp_rot u_rot_x (
		.clk(clk),
		.arst_n(arst_n),
		.valid(go),
		.a(in_y),
		.b(in_z),
		.pass(in_x),
		.coef_c(cfg.cos_x),
		.coef_s(cfg.sin_x),
		.done(v1),
		.held(h1),
		.dif(d1),
		.sum(s1)
	);

	// about y: z2 = dif, x2 = sum
	prp_rot u_rot_y (
		.clk(clk),
		.arst_n(arst_n),
		.valid(v1),
		.a(prp_pkg::ROT_W'(s1)),
		.b(h1),
		.pass(prp_pkg::ROT_W'(d1)),
		.coef_c(cfg.cos_y),
		.coef_s(cfg.sin_y),
		.done(v2),
		.held(h2),
		.dif(d2),
		.sum(s2)
	);

	// about z: x3 = dif, y3 = sum
	prp_rot u_rot_z (
		.clk(clk),
		.arst_n(arst_n),
		.valid(v2),
		.a(prp_pkg::ROT_W'(s2)),
		.b(h2),
		.pass(prp_pkg::ROT_W'(d2)),
		.coef_c(cfg.cos_z),
		.coef_s(cfg.sin_z),
		.done(v3),
		.held(h3),
		.dif(d3),
		.sum(s3)
	);

	prp_proj u_proj (
		.clk(clk),
		.arst_n(arst_n),
		.valid(v3),
		.rx(d3),
		.ry(s3),
		.rz(h3),
		.half_w(cfg.screen_width[prp_pkg::CFG_W-1:1]),
		.half_h(cfg.screen_height[prp_pkg::CFG_W-1:1]),
		.done(done),
		.result(result)
	);

endmodule
